// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/fftq16_pkg.sv =====
// ----------------------------------------------------------------------------
// FFT Q16 package
// Shared types, the twiddle table and controller command bundle.
// ----------------------------------------------------------------------------
package fftq16_pkg;

    localparam int RomPoints = 64;

    typedef struct packed {
        logic        load_wr;   // write a sample into the load bank
        logic [5:0]  load_addr;
        logic [5:0]  rd_a;
        logic [5:0]  rd_b;
        logic        src_b;     // read from bank B when set
        logic        rd_out;    // read is an output read
        logic [5:0]  wr_c;
        logic [5:0]  wr_d;
        logic [4:0]  tw_idx;
        logic        bf_issue;  // data of this read feeds the butterfly
    } fftq16_cmd_t;

    function automatic logic signed [17:0] cos_q16(input logic [4:0] k);
        logic signed [17:0] r;
        case (k)
            5'd0: r = 18'sd65536;
            5'd1: r = 18'sd65220;
            5'd2: r = 18'sd64276;
            5'd3: r = 18'sd62714;
            5'd4: r = 18'sd60547;
            5'd5: r = 18'sd57797;
            5'd6: r = 18'sd54491;
            5'd7: r = 18'sd50660;
            5'd8: r = 18'sd46340;
            5'd9: r = 18'sd41575;
            5'd10: r = 18'sd36409;
            5'd11: r = 18'sd30893;
            5'd12: r = 18'sd25079;
            5'd13: r = 18'sd19024;
            5'd14: r = 18'sd12785;
            5'd15: r = 18'sd6423;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [35:0] twiddle(input logic [4:0] i);
        logic signed [17:0] wr;
        logic signed [17:0] wi;
        if (i <= 5'd16)
        begin
            wr = cos_q16(i);
            wi = cos_q16(5'd16 - i);
        end
        else
        begin
            wr = -cos_q16(5'd0 - i) - 18'sd1;
            wi = cos_q16(i - 5'd16);
        end
        return {wr, wi};
    endfunction

endpackage

// ===== design/fftq16_ram.sv =====
// ----------------------------------------------------------------------------
// FFT Q16 RAM
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fftq16_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ===== design/fftq16_datapath.sv =====
// ----------------------------------------------------------------------------
// FFT Q16 datapath
// Two ping-pong banks, each held as two RAMs, and a pipelined butterfly.
// ----------------------------------------------------------------------------
module fftq16_datapath
    import fftq16_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fftq16_cmd_t        cmd,
    input  logic signed [15:0] sample,
    output logic [63:0]        out_word,
    output logic               wb_busy
);
    localparam int AW = $clog2(POINTS);

    // Each bank keeps two copies so that a and b are read in the same cycle.
    logic [63:0]   qa0, qa1, qb0, qb1;
    logic [AW-1:0] ra0, ra1;

    // Pipeline: s1 read data, s2 products, s3 write.
    logic          s1_v_reg, s1_src_b_reg;
    logic [AW-1:0] s1_c_reg, s1_d_reg;
    logic [4:0]    s1_tw_reg;
    logic          s2_v_reg, s2_dst_b_reg;
    logic [AW-1:0] s2_c_reg, s2_d_reg;
    logic [63:0]   s2_sum_reg;
    logic signed [63:0] s2_p0_reg, s2_p1_reg, s2_p2_reg, s2_p3_reg;
    logic          s3_v_reg, s3_dst_b_reg;
    logic [AW-1:0] s3_c_reg, s3_d_reg;
    logic [63:0]   s3_sum_reg, s3_dif_reg;
    logic          s1_out_reg;

    // The d result follows c into the bank in the next cycle.
    logic          dq_v_reg, dq_b_reg;
    logic [AW-1:0] dq_a_reg;
    logic [63:0]   dq_w_reg;
    logic          wsel_a, wsel_b;
    logic [AW-1:0] wad;
    logic [63:0]   wdd;

    logic [63:0] a_w, b_w;
    logic signed [31:0] dr, di;
    logic [35:0] tw_w;
    logic signed [17:0] wr, wi;
    logic signed [63:0] pre, pim;

    assign ra0 = cmd.rd_a[AW-1:0];
    assign ra1 = cmd.rd_b[AW-1:0];

    always_comb
    begin
        wsel_a = 1'b0;
        wsel_b = 1'b0;
        wad    = s3_c_reg;
        wdd    = s3_sum_reg;
        if (cmd.load_wr)
        begin
            wsel_a = 1'b1;
            wad    = cmd.load_addr[AW-1:0];
            wdd    = {{16{sample[15]}}, sample, 32'd0};
        end
        else if (s3_v_reg)
        begin
            wsel_a = !s3_dst_b_reg;
            wsel_b = s3_dst_b_reg;
        end
        else if (dq_v_reg)
        begin
            wsel_a = !dq_b_reg;
            wsel_b = dq_b_reg;
            wad    = dq_a_reg;
            wdd    = dq_w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_v_reg <= 1'b0;
        end
        else
        begin
            dq_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg)
        begin
            dq_b_reg <= s3_dst_b_reg;
            dq_a_reg <= s3_d_reg;
            dq_w_reg <= s3_dif_reg;
        end
    end

    assign wb_busy = s1_v_reg || s2_v_reg || s3_v_reg || dq_v_reg;

    fftq16_ram #(.WIDTH(64), .DEPTH(POINTS)) u_a0 (
        .clk(clk), .we(wsel_a), .waddr(wad), .wdata(wdd), .raddr(ra0), .rdata(qa0));
    fftq16_ram #(.WIDTH(64), .DEPTH(POINTS)) u_a1 (
        .clk(clk), .we(wsel_a), .waddr(wad), .wdata(wdd), .raddr(ra1), .rdata(qa1));
    fftq16_ram #(.WIDTH(64), .DEPTH(POINTS)) u_b0 (
        .clk(clk), .we(wsel_b), .waddr(wad), .wdata(wdd), .raddr(ra0), .rdata(qb0));
    fftq16_ram #(.WIDTH(64), .DEPTH(POINTS)) u_b1 (
        .clk(clk), .we(wsel_b), .waddr(wad), .wdata(wdd), .raddr(ra1), .rdata(qb1));

    assign a_w = s1_src_b_reg ? qb0 : qa0;
    assign b_w = s1_src_b_reg ? qb1 : qa1;
    assign out_word = a_w;
    assign dr = a_w[63:32] - b_w[63:32];
    assign di = a_w[31:0] - b_w[31:0];
    assign tw_w = twiddle(s1_tw_reg);
    assign wr = tw_w[35:18];
    assign wi = tw_w[17:0];
    assign pre = s2_p0_reg + s2_p1_reg;
    assign pim = s2_p2_reg - s2_p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.bf_issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_src_b_reg <= cmd.src_b;
        s1_out_reg   <= cmd.rd_out;
        s1_c_reg     <= cmd.wr_c[AW-1:0];
        s1_d_reg     <= cmd.wr_d[AW-1:0];
        s1_tw_reg    <= cmd.tw_idx;
        s2_dst_b_reg <= !s1_src_b_reg;
        s2_c_reg     <= s1_c_reg;
        s2_d_reg     <= s1_d_reg;
        s2_sum_reg   <= {a_w[63:32] + b_w[63:32], a_w[31:0] + b_w[31:0]};
        s2_p0_reg    <= 64'(wr * dr);
        s2_p1_reg    <= 64'(wi * di);
        s2_p2_reg    <= 64'(wr * di);
        s2_p3_reg    <= 64'(wi * dr);
        s3_dst_b_reg <= s2_dst_b_reg;
        s3_c_reg     <= s2_c_reg;
        s3_d_reg     <= s2_d_reg;
        s3_sum_reg   <= s2_sum_reg;
        s3_dif_reg   <= {pre[47:16], pim[47:16]};
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_no_out_bf, clk, rst_n, s1_v_reg, !s1_out_reg)
    `ASSERT_NXT(a_s3_follow, clk, rst_n, s2_v_reg, s3_v_reg)
    `ASSERT_IMP(a_no_dual_wr, clk, rst_n, s3_v_reg, !cmd.load_wr)
    `ASSERT_IMP(a_one_bf_wr, clk, rst_n, s3_v_reg, !dq_v_reg)
endmodule

// ===== design/fftq16_ctrl.sv =====
// ----------------------------------------------------------------------------
// FFT Q16 controller
// Sequences load, butterfly stages and the output of one frame.
// ----------------------------------------------------------------------------
module fftq16_ctrl
    import fftq16_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        last,
    output fftq16_cmd_t cmd,
    input  logic        wb_busy
);
    localparam int AW = $clog2(POINTS);
    localparam int HALF = POINTS / 2;
    localparam int TwStep = RomPoints / POINTS;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_BFLY  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_OUT   = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW-1:0] bcnt_reg, bcnt_next;
    logic [AW-1:0] mj_log_reg, mj_log_next;
    logic          bank_b_reg, bank_b_next;
    logic [AW-1:0] ocnt_reg, ocnt_next;
    logic          ov_reg, ov_next;
    logic          pend_reg, pend_next;
    logic          ph_reg, ph_next;

    logic [AW-1:0] kmask, j_w, k_w, jw, jc, mj;
    logic          rd_fire;

    assign mj    = AW'(1) << mj_log_reg;
    assign kmask = mj - AW'(1);
    assign k_w   = bcnt_reg & kmask;
    assign jw    = bcnt_reg & ~kmask;
    assign jc    = AW'({1'b0, jw} << 1);
    assign j_w   = jw;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = ov_reg;
    assign last      = ov_reg && (ocnt_reg == AW'(POINTS - 1));
    // Output read issued when output register free or being emptied.
    assign rd_fire   = (state_reg == ST_OUT) && !pend_reg
                       && (cnt_reg != (AW+1)'(POINTS)) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bcnt_next   = bcnt_reg;
        mj_log_next = mj_log_reg;
        bank_b_next = bank_b_reg;
        ocnt_next   = ocnt_reg;
        ov_next     = ov_reg;
        pend_next   = pend_reg;
        ph_next     = ph_reg;
        cmd         = '0;
        cmd.src_b   = bank_b_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_addr = 6'(cnt_reg[AW-1:0]);
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (cnt_reg == (AW+1)'(POINTS - 1))
                    begin
                        cnt_next    = '0;
                        bcnt_next   = '0;
                        mj_log_next = '0;
                        bank_b_next = 1'b0;
                        ph_next     = 1'b0;
                        state_next  = ST_BFLY;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_BFLY:
            begin
                // A butterfly writes two entries through one write port,
                // so issue alternates with an idle phase on ph_reg.
                cmd.bf_issue = !ph_reg;
                cmd.rd_a     = 6'(jw + k_w);
                cmd.rd_b     = 6'(AW'(HALF) + jw + k_w);
                cmd.wr_c     = 6'(jc + k_w);
                cmd.wr_d     = 6'(jc + mj + k_w);
                cmd.tw_idx   = 5'(32'(j_w) * TwStep);
                ph_next      = !ph_reg;
                if (ph_reg)
                begin
                    if (bcnt_reg == AW'(HALF - 1))
                    begin
                        bcnt_next  = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        bcnt_next = bcnt_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!wb_busy)
                begin
                    bank_b_next = !bank_b_reg;
                    if (mj_log_reg == AW'(AW - 1))
                    begin
                        ocnt_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        mj_log_next = mj_log_reg + 1'b1;
                        state_next  = ST_BFLY;
                    end
                end
            end
            ST_OUT:
            begin
                cmd.rd_a   = 6'(cnt_reg[AW-1:0]);
                cmd.rd_out = rd_fire;
                if (ov_reg && out_ready)
                begin
                    ov_next = 1'b0;
                    if (ocnt_reg == AW'(POINTS - 1))
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        ocnt_next = ocnt_reg + 1'b1;
                    end
                end
                if (rd_fire)
                begin
                    pend_next = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // Registered read data becomes the output register.
                cmd.rd_a   = 6'(cnt_reg[AW-1:0]);
                pend_next  = 1'b0;
                ov_next    = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_OUT;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            bcnt_reg   <= '0;
            mj_log_reg <= '0;
            bank_b_reg <= 1'b0;
            ocnt_reg   <= '0;
            ov_reg     <= 1'b0;
            pend_reg   <= 1'b0;
            ph_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            bcnt_reg   <= bcnt_next;
            mj_log_reg <= mj_log_next;
            bank_b_reg <= bank_b_next;
            ocnt_reg   <= ocnt_next;
            ov_reg     <= ov_next;
            pend_reg   <= pend_next;
            ph_reg     <= ph_next;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_no_in_out, clk, rst_n, in_ready, !out_valid)
    `ASSERT_NXT(a_hold_ov, clk, rst_n, state_reg == ST_HOLD, out_valid)
    `ASSERT_IMP(a_last_cnt, clk, rst_n, last, ocnt_reg == AW'(POINTS - 1))
endmodule

// ===== design/fft_radix2_fixed_q16.sv =====
// ----------------------------------------------------------------------------
// Radix-2 fixed-point FFT, Q16 twiddles
// A frame takes POINTS sample beats, then log2(POINTS) stages of POINTS/2
// butterflies on one pipelined butterfly unit. Each bank has a single write
// port and a butterfly writes two entries, so butterfly issue alternates
// with an idle phase, and each stage ends with a drain until the butterfly
// pipeline is empty. Then POINTS bin beats follow in natural order, each bin
// passing through the registered bank read. No sample is accepted while a
// frame is processed or its bins are sent.
// ----------------------------------------------------------------------------
module fft_radix2_fixed_q16
    import fftq16_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] bin_re,
    output logic signed [31:0] bin_im,
    output logic               bin_last
);
    fftq16_cmd_t cmd;
    logic        wb_busy, last;
    logic [63:0] out_word;
    logic [63:0] obuf_reg;
    logic        hold_q_reg;

    fftq16_ctrl #(.POINTS(POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .last(last),
        .cmd(cmd), .wb_busy(wb_busy));

    fftq16_datapath #(.POINTS(POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(sample),
        .out_word(out_word), .wb_busy(wb_busy));

    // The RAM output is valid the cycle after an output read; capture it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_q_reg <= 1'b0;
        end
        else
        begin
            hold_q_reg <= cmd.rd_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_q_reg)
        begin
            obuf_reg <= out_word;
        end
    end

    assign bin_re   = hold_q_reg ? out_word[63:32] : obuf_reg[63:32];
    assign bin_im   = hold_q_reg ? out_word[31:0] : obuf_reg[31:0];
    assign bin_last = last;
endmodule
